[design/qie_pkg.sv]
// Shared types and codes for the quadtree image encoder.
package qie_pkg;

	typedef enum logic [1:0] {
		SYM_B    = 2'd0,
		SYM_P    = 2'd1,
		SYM_X    = 2'd2,
		SYM_DONE = 2'd3
	} sym_t;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_RUN  = 2'd1,
		PH_DONE = 2'd2
	} phase_t;

	typedef enum logic [2:0] {
		ST_IDLE   = 3'd0,
		ST_PREP   = 3'd1,
		ST_SCAN   = 3'd2,
		ST_PUSH   = 3'd3,
		ST_SETTLE = 3'd4
	} state_t;

	localparam logic CFG_WIDTH  = 1'b0;
	localparam logic CFG_HEIGHT = 1'b1;

	typedef struct packed {
		logic load;
		logic pull;
		logic scan_init;
		logic scan;
		logic push;
		logic settle;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic pull_none;
		logic scan_done;
		logic settled;
		logic out_free;
	} status_t;

endpackage

[design/qie_ctrl.sv]
// Controller state machine of the quadtree image encoder.
module qie_ctrl import qie_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	input  logic    action,
	output logic    in_stall,
	input  status_t status,
	output cmd_t    cmd
);

	state_t state_q, state_d;
	logic   accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		in_stall = (state_q != ST_IDLE) || (action && !status.out_free);
		accept   = in_valid && !in_stall;
		cmd      = '0;
		state_d  = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (action) begin
						cmd.pull = 1'b1;
						if (!status.pull_none) state_d = ST_PREP;
					end else begin
						cmd.load = 1'b1;
					end
				end
			end
			ST_PREP: begin
				cmd.scan_init = 1'b1;
				state_d = ST_SCAN;
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				if (status.scan_done) state_d = ST_PUSH;
			end
			ST_PUSH: begin
				cmd.push = 1'b1;
				state_d = ST_SETTLE;
			end
			ST_SETTLE: begin
				cmd.settle = 1'b1;
				if (status.settled && status.out_free) begin
					cmd.emit = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

[design/qie_datapath.sv]
// Datapath of the quadtree image encoder: pixel store, region stack, scanner, output register.
module qie_datapath import qie_pkg::*; #(
	parameter int MAX_WIDTH   = 64,
	parameter int MAX_HEIGHT  = 64,
	parameter int STACK_DEPTH = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	input  cmd_t       cmd,
	output status_t    status,
	input  logic       pixel_value,
	input  logic       first_pixel_flag,
	input  logic       cfg_valid,
	input  logic       cfg_index,
	input  logic [6:0] cfg_data,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [1:0] symbol,
	output logic       last_symbol
);

	localparam int STORE = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = $clog2(STORE);
	localparam int RW    = $clog2(MAX_HEIGHT);
	localparam int CW    = $clog2(MAX_WIDTH);
	localparam int WW    = $clog2(MAX_WIDTH + 1);
	localparam int HW    = $clog2(MAX_HEIGHT + 1);
	localparam int SPW   = $clog2(STACK_DEPTH + 1);
	localparam int TW    = $clog2(STACK_DEPTH);

	logic          mem [STORE];
	logic [6:0]    width_q, height_q;
	logic [WW-1:0] run_width_q, width_eff;
	logic [HW-1:0] height_eff;
	phase_t        phase_q, eff_phase;
	logic [SPW-1:0] sp_q, eff_sp;
	logic [AW-1:0] load_addr_q, wr_addr, rd_addr, row_base_q;

	logic [RW-1:0] fr_r0 [STACK_DEPTH];
	logic [RW-1:0] fr_r1 [STACK_DEPTH];
	logic [CW-1:0] fr_c0 [STACK_DEPTH];
	logic [CW-1:0] fr_c1 [STACK_DEPTH];
	logic [2:0]    fr_q  [STACK_DEPTH];
	logic [TW-1:0] top_idx, push_idx;

	logic [RW-1:0] reg_r0_q, reg_r1_q, scan_r_q;
	logic [CW-1:0] reg_c0_q, reg_c1_q, scan_c_q;
	logic          issued_all_q, first_pend_q;
	logic          rd_data_s1, rd_valid_s1, rd_first_s1, rd_last_s1;
	logic          ref_q, cmp_ref, mismatch, scan_done;
	sym_t          sym_q, out_sym_q;
	logic          out_valid_q, out_last_q;

	logic [RW:0]   mr, qr0, qr1;
	logic [CW:0]   mc, qc0, qc1;
	logic [1:0]    tq;
	logic          q_nonempty;

	always_comb begin
		width_eff = (width_q == 7'd0) ? WW'(1) :
			((32'(width_q) > MAX_WIDTH) ? WW'(MAX_WIDTH) : WW'(width_q));
		height_eff = (height_q == 7'd0) ? HW'(1) :
			((32'(height_q) > MAX_HEIGHT) ? HW'(MAX_HEIGHT) : HW'(height_q));
		eff_phase = first_pixel_flag ? PH_IDLE : phase_q;
		eff_sp    = first_pixel_flag ? '0 : sp_q;
		top_idx   = TW'(sp_q - SPW'(1));
		push_idx  = TW'(sp_q);
		tq        = fr_q[top_idx][1:0];
		mr  = ({1'b0, fr_r0[top_idx]} + {1'b0, fr_r1[top_idx]}) >> 1;
		mc  = ({1'b0, fr_c0[top_idx]} + {1'b0, fr_c1[top_idx]}) >> 1;
		qr0 = tq[1] ? mr + (RW+1)'(1) : {1'b0, fr_r0[top_idx]};
		qr1 = tq[1] ? {1'b0, fr_r1[top_idx]} : mr;
		qc0 = tq[0] ? mc + (CW+1)'(1) : {1'b0, fr_c0[top_idx]};
		qc1 = tq[0] ? {1'b0, fr_c1[top_idx]} : mc;
		q_nonempty = (qr0 <= qr1) && (qc0 <= qc1);

		wr_addr  = first_pixel_flag ? '0 : load_addr_q;
		rd_addr  = row_base_q + AW'(scan_c_q);
		cmp_ref  = rd_first_s1 ? rd_data_s1 : ref_q;
		mismatch = rd_valid_s1 && (rd_data_s1 != cmp_ref);
		scan_done = rd_valid_s1 && (rd_last_s1 || mismatch);

		status.pull_none = !(eff_phase == PH_IDLE) &&
			!((eff_phase == PH_RUN) && (eff_sp != '0));
		status.scan_done = scan_done;
		status.settled   = (sp_q == '0) || (!fr_q[top_idx][2] && q_nonempty);
		status.out_free  = !out_valid_q || !out_stall;
	end

	// store: one write port for loads, one registered read port for the scan
	always_ff @(posedge clk) begin
		if (cmd.load) mem[wr_addr] <= pixel_value;
		rd_data_s1 <= mem[rd_addr];
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q      <= 7'd64;
			height_q     <= 7'd64;
			run_width_q  <= WW'(MAX_WIDTH);
			phase_q      <= PH_IDLE;
			sp_q         <= '0;
			load_addr_q  <= '0;
			issued_all_q <= 1'b0;
			first_pend_q <= 1'b0;
			rd_valid_s1  <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_valid) begin
				if (cfg_index == CFG_WIDTH) width_q <= cfg_data;
				else height_q <= cfg_data;
			end
			if (cmd.load) begin
				load_addr_q <= (wr_addr == AW'(STORE - 1)) ? '0 : wr_addr + AW'(1);
				if (first_pixel_flag) begin
					phase_q <= PH_IDLE;
					sp_q    <= '0;
				end
			end
			if (cmd.pull) begin
				if (first_pixel_flag) load_addr_q <= '0;
				if (eff_phase == PH_IDLE) begin
					phase_q     <= PH_RUN;
					sp_q        <= '0;
					run_width_q <= width_eff;
				end else if (status.pull_none) begin
					phase_q <= PH_DONE;
					sp_q    <= eff_sp;
				end
			end
			if (cmd.push && sym_q == SYM_X && 32'(sp_q) < STACK_DEPTH) sp_q <= sp_q + SPW'(1);
			if (cmd.settle && sp_q != '0 && fr_q[top_idx][2]) sp_q <= sp_q - SPW'(1);
			if (cmd.emit && sp_q == '0) phase_q <= PH_DONE;

			if (cmd.scan_init) begin
				issued_all_q <= 1'b0;
				first_pend_q <= 1'b1;
				rd_valid_s1  <= 1'b0;
			end else if (cmd.scan) begin
				rd_valid_s1 <= !issued_all_q;
				if (!issued_all_q) begin
					first_pend_q <= 1'b0;
					if (scan_c_q == reg_c1_q && scan_r_q == reg_r1_q) issued_all_q <= 1'b1;
				end
			end

			if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
			if ((cmd.pull && status.pull_none) || cmd.emit) out_valid_q <= 1'b1;
		end
	end

	// payload: region, stack frames, scan counters, output data
	always_ff @(posedge clk) begin
		if (cmd.pull) begin
			if (eff_phase == PH_IDLE) begin
				reg_r0_q <= '0;
				reg_c0_q <= '0;
				reg_r1_q <= RW'(height_eff - HW'(1));
				reg_c1_q <= CW'(width_eff - WW'(1));
			end else if (!status.pull_none) begin
				reg_r0_q <= RW'(qr0);
				reg_r1_q <= RW'(qr1);
				reg_c0_q <= CW'(qc0);
				reg_c1_q <= CW'(qc1);
				fr_q[top_idx] <= fr_q[top_idx] + 3'd1;
			end else begin
				out_sym_q  <= SYM_DONE;
				out_last_q <= 1'b0;
			end
		end
		if (cmd.push && sym_q == SYM_X && 32'(sp_q) < STACK_DEPTH) begin
			fr_r0[push_idx] <= reg_r0_q;
			fr_r1[push_idx] <= reg_r1_q;
			fr_c0[push_idx] <= reg_c0_q;
			fr_c1[push_idx] <= reg_c1_q;
			fr_q[push_idx]  <= 3'd0;
		end
		if (cmd.settle && sp_q != '0 && !fr_q[top_idx][2] && !q_nonempty)
			fr_q[top_idx] <= fr_q[top_idx] + 3'd1;

		if (cmd.scan_init) begin
			scan_r_q   <= reg_r0_q;
			scan_c_q   <= reg_c0_q;
			row_base_q <= AW'(32'(reg_r0_q) * 32'(run_width_q));
		end else if (cmd.scan) begin
			if (!issued_all_q) begin
				rd_first_s1 <= first_pend_q;
				rd_last_s1  <= (scan_c_q == reg_c1_q) && (scan_r_q == reg_r1_q);
				if (scan_c_q == reg_c1_q) begin
					scan_c_q   <= reg_c0_q;
					scan_r_q   <= scan_r_q + RW'(1);
					row_base_q <= row_base_q + AW'(run_width_q);
				end else begin
					scan_c_q <= scan_c_q + CW'(1);
				end
			end
			if (rd_valid_s1 && rd_first_s1) ref_q <= rd_data_s1;
			if (scan_done) sym_q <= mismatch ? SYM_X : (cmp_ref ? SYM_P : SYM_B);
		end
		if (cmd.emit) begin
			out_sym_q  <= sym_q;
			out_last_q <= (sp_q == '0);
		end
	end

	assign out_valid   = out_valid_q;
	assign symbol      = out_sym_q;
	assign last_symbol = out_last_q;

endmodule

[design/quadtree_image_encoder_core.sv]
// Top level of the quadtree image encoder: controller plus datapath.
//
// Input channel (in_valid/in_stall): each beat either loads one pixel
// (action 0) at the next row-major store address, or pulls the next code
// symbol (action 1). first_pixel_flag restarts loading at address 0 and
// returns encoding to idle before the beat's action is done.
// Output channel (out_valid/out_stall): one beat per pull carrying symbol
// (B, P, X or done) and last_symbol; loads give no beat.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data write
// image_width (index 0) and image_height (index 1); always ready.
// Timing: the pixel scan reads the store's single read port one pixel
// per cycle, so region size sets how long a pull that codes a region
// takes, and each stack frame skipped or popped adds to it. A pull after
// the code is done is answered without a scan.
// Reset clears the load address, stack pointer and encode phase and sets
// both dimensions to 64; the pixel store is not cleared.
// A stalled output beat holds; loads are still taken meanwhile, and a
// pull waits until the output register is free.
module quadtree_image_encoder_core import qie_pkg::*; #(
	parameter int MAX_WIDTH   = 64,
	parameter int MAX_HEIGHT  = 64,
	parameter int STACK_DEPTH = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       action,
	input  logic       pixel_value,
	input  logic       first_pixel_flag,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [1:0] symbol,
	output logic       last_symbol,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic       cfg_index,
	input  logic [6:0] cfg_data
);

	cmd_t    cmd;
	status_t status;

	// registers are taken whenever offered
	assign cfg_ready = 1'b1;

	qie_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.action   (action),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	qie_datapath #(
		.MAX_WIDTH   (MAX_WIDTH),
		.MAX_HEIGHT  (MAX_HEIGHT),
		.STACK_DEPTH (STACK_DEPTH)
	) u_datapath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.status           (status),
		.pixel_value      (pixel_value),
		.first_pixel_flag (first_pixel_flag),
		.cfg_valid        (cfg_valid),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.symbol           (symbol),
		.last_symbol      (last_symbol)
	);

endmodule
